FILE: sv/dmng_pkg.sv
// Shared constants and types for the division magic-number generator.
package dmng_pkg;

    localparam int WORD_BITS  = 32;
    localparam int DIV_BITS   = WORD_BITS - 1;
    localparam int SHIFT_BITS = $clog2(WORD_BITS);
    localparam int CNT_BITS   = $clog2(WORD_BITS);

    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(WORD_BITS - 1);

    typedef logic [DIV_BITS-1:0]   t_divisor;
    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [SHIFT_BITS-1:0] t_shift;
    typedef logic [CNT_BITS-1:0]   t_count;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

endpackage

FILE: sv/division_magic_number_gen_unit.sv
// Division magic-number generator: multiplier and shift for divide-by-constant.
//
// Input channel: i_in_valid / o_in_stall carry one divisor request on
// i_divisor. A request is taken at a clock edge with i_in_valid high and
// o_in_stall low. o_in_stall is high while a divisor is being worked on.
// Output channel: o_out_valid / i_out_stall carry o_multiplier,
// o_extra_shift and o_divisor_zero from an output register.
// Order of work: a setup state, ST_PREP (leading-one search, power-of-two
// test), a shared restoring-divide step (shift, compare, subtract) in
// ST_DIV, repeated once per quotient bit for 32 bits, and ST_FIN, which
// rounds and loads the output register. Zero and one skip the divide. No
// new divisor is taken until the previous result is in the output register.
// A new request is taken while a finished result still sits in the output
// register; if that register is full and stalled when the next result is
// ready, the block holds the result until the register drains.
// Reset (i_rst_n low, synchronous) returns to idle and empties the output.
// A zero divisor raises o_divisor_zero with zero coefficients.
module division_magic_number_gen_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dmng_pkg::t_divisor i_divisor,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dmng_pkg::t_word    o_multiplier,
    output dmng_pkg::t_shift   o_extra_shift,
    output logic               o_divisor_zero
);
    import dmng_pkg::*;

    t_state   r_state, n_state;
    t_divisor r_div,   n_div;
    t_word    r_rem,   n_rem;
    t_word    r_quot,  n_quot;
    t_count   r_cnt,   n_cnt;
    t_shift   r_sh,    n_sh;
    logic     r_zero,  n_zero;

    logic     r_out_valid, n_out_valid;
    t_word    r_mult,      n_mult;
    t_shift   r_oshift,    n_oshift;
    logic     r_ozero,     n_ozero;

    t_shift   top_idx;
    logic     is_pow2;
    t_shift   prep_sh;
    t_word    rem_dbl;
    t_word    rem_sub;
    logic     rem_ge;
    logic     out_free;

    // leading-one position of the held divisor
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            if (r_div[i]) top_idx = SHIFT_BITS'(i);
        end
    end

    assign is_pow2 = ((r_div & (r_div - t_divisor'(1))) == '0);
    // shift = ceil(log2 d) - 1
    assign prep_sh = is_pow2 ? (top_idx - t_shift'(1)) : top_idx;

    // shared divide step
    assign rem_dbl = {r_rem[WORD_BITS-2:0], 1'b0};
    assign rem_ge  = (rem_dbl >= {1'b0, r_div});
    assign rem_sub = rem_dbl - {1'b0, r_div};

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_cnt       = r_cnt;
        n_sh        = r_sh;
        n_zero      = r_zero;
        n_out_valid = r_out_valid && i_out_stall;
        n_mult      = r_mult;
        n_oshift    = r_oshift;
        n_ozero     = r_ozero;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_div   = i_divisor;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_cnt = '0;
                if (r_div[DIV_BITS-1:1] == '0) begin
                    // zero or one: no coefficients
                    n_zero  = !r_div[0];
                    n_sh    = '0;
                    n_quot  = '0;
                    n_rem   = '0;
                    n_state = ST_FIN;
                end else begin
                    // partial remainder 2^(k-1) < d, then 32 quotient bits
                    n_zero  = 1'b0;
                    n_sh    = prep_sh;
                    n_quot  = '0;
                    n_rem   = t_word'(1) << prep_sh;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem  = rem_ge ? rem_sub : rem_dbl;
                n_quot = {r_quot[WORD_BITS-2:0], rem_ge};
                n_cnt  = r_cnt + t_count'(1);
                if (r_cnt == LAST_STEP) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    // round up when the division left a remainder
                    n_mult      = r_quot + t_word'(r_rem != '0);
                    n_oshift    = r_sh;
                    n_ozero     = r_zero;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_quot   <= n_quot;
        r_cnt    <= n_cnt;
        r_sh     <= n_sh;
        r_zero   <= n_zero;
        r_mult   <= n_mult;
        r_oshift <= n_oshift;
        r_ozero  <= n_ozero;
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_multiplier   = r_mult;
    assign o_extra_shift  = r_oshift;
    assign o_divisor_zero = r_ozero;

endmodule

FILE: sv/dmng_chk.sv
// Port-level checker for the division magic-number generator, with its bind.
module dmng_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  dmng_pkg::t_divisor i_divisor,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  dmng_pkg::t_word    o_multiplier,
    input  dmng_pkg::t_shift   o_extra_shift,
    input  logic               o_divisor_zero
);
    import dmng_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_multiplier)
            && $stable(o_extra_shift) && $stable(o_divisor_zero))
        else $error("stalled result changed");

    // a taken request keeps the block busy for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block not busy after taking a request");

    // zero divisor gives zero coefficients
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divisor_zero |-> o_multiplier == '0 && o_extra_shift == '0)
        else $error("zero divisor with nonzero coefficients");

    // a nonzero multiplier is at least 2^(WORD_BITS-1) and comes with o_divisor_zero low
    a_mult_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_multiplier != '0 |-> o_multiplier[WORD_BITS-1]
            && !o_divisor_zero)
        else $error("multiplier out of range");

    // a stalled request stays up with the same divisor
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_divisor))
        else $error("stalled request changed");

endmodule

bind division_magic_number_gen_unit dmng_chk u_dmng_chk (.*);
